FILE: src/bma_pkg.sv
// Shared types for the buddy allocator: opcodes, datapath commands, status.
// No dependencies; used by bma_ctrl, bma_datapath and the top level.
package bma_pkg;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // datapath micro-operations
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LVL_UP,
    CMD_POP_RD,
    CMD_POP_SPLIT,
    CMD_POP_TAKE,
    CMD_PUSH_HI,
    CMD_PUSH_LO,
    CMD_PUSH_FREE,
    CMD_WALK_INIT,
    CMD_WALK_RD,
    CMD_WALK_CHK
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    out_load;
    logic    out_fail;
  } dp_cmd_t;

  typedef struct packed {
    logic oversize;
    logic lvl_empty;
    logic lvl_gt_want;
    logic lvl_below_top;
    logic walk_live;
    logic walk_hit;
    logic node_bad;
  } dp_sts_t;

endpackage

FILE: src/buddy_memory_allocator_unit.sv
// Top level of the buddy allocator: stream ports, controller and datapath.
// Depends on bma_pkg, bma_ctrl and bma_datapath.
//
//   channel | direction | tdata                          | tuser
//   in_     | slave     | request_size, block_address    | opcode
//   out_    | master     | result_address                 | failed
//
// One request at a time, taken only in idle. Allocate: accept, dispatch,
// scan per level, read, write and two pushes per split, read and write to
// take, post. Free: accept, dispatch, per level a check, a read and check
// per entry walked, one more read for a missing buddy, push, post. Oversize:
// accept, dispatch, post. Reset is synchronous; no clearing pass is needed.
// A result not yet taken holds the next request in its post state.
module buddy_memory_allocator_unit #(
  parameter int MEM_UNITS = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // request_size [SW-1:0], block_address above it, zero fill
  input  logic [((2 * $clog2(MEM_UNITS) + 8) / 8) * 8 - 1:0] in_tdata,
  // opcode
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // result_address, zero fill
  output logic [(($clog2(MEM_UNITS) + 7) / 8) * 8 - 1:0] out_tdata,
  // failed
  output logic out_tuser
);
  import bma_pkg::*;

  localparam int AW     = $clog2(MEM_UNITS);
  localparam int SW     = AW + 1;
  localparam int OUT_DW = ((AW + 7) / 8) * 8;

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] res_addr;
  logic          res_fail;

  // sequencing
  bma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lists and link memory
  bma_datapath #(
    .MEM_UNITS (MEM_UNITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_size  (in_tdata[SW-1:0]),
    .in_addr  (in_tdata[SW+AW-1:SW]),
    .sts      (sts),
    .out_addr (res_addr),
    .out_fail (res_fail)
  );

  assign out_tdata = OUT_DW'(res_addr);
  assign out_tuser = res_fail;

  // the block is busy in the cycle after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  // a new result is posted only on the return to idle
  a_post_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result posted while busy");

  // a failed allocate reports address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("failed result with nonzero address");

  // no result is posted in the cycle after a request is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> !out_tvalid)
    else $error("result posted too early");

endmodule

FILE: src/bma_datapath.sv
// Datapath of the buddy allocator: level heads, link memory, walk registers.
// Depends on bma_pkg; driven by bma_ctrl through dp_cmd_t.
module bma_datapath #(
  parameter int MEM_UNITS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bma_pkg::dp_cmd_t                  cmd,
  input  logic [$clog2(MEM_UNITS):0]        in_size,
  input  logic [$clog2(MEM_UNITS)-1:0]      in_addr,
  output bma_pkg::dp_sts_t                  sts,
  output logic [$clog2(MEM_UNITS)-1:0]      out_addr,
  output logic                              out_fail
);
  import bma_pkg::*;

  localparam int AW     = $clog2(MEM_UNITS);
  localparam int SW     = AW + 1;
  localparam int NW     = AW + 1;
  localparam int LEVELS = AW + 1;
  localparam int LW     = $clog2(LEVELS + 1);
  localparam int HD     = 2 ** LW;
  localparam logic [NW-1:0] NIL  = NW'(2 * MEM_UNITS - 1);
  localparam logic [NW-1:0] MEMC = NW'(MEM_UNITS);

  logic [NW-1:0] head_r [HD];
  logic [NW-1:0] node_mem [2 ** NW];
  logic [NW-1:0] mem_q;
  logic          rd_nil_r;
  logic          n0_wr_r;

  logic [LW-1:0] lvl_r, want_r;
  logic [AW-1:0] idx_r, res_r, out_addr_r;
  logic          out_fail_r;
  logic [NW-1:0] node_r, cur_r, prev_r, target_r, steps_r;

  logic [SW-1:0] s_m1;
  logic [LW-1:0] size_lvl;
  logic [NW-1:0] rdata, head_cur, base_cur, push_node;
  logic          hit, mem_re, mem_we, head_we;
  logic [NW-1:0] mem_raddr, mem_waddr, mem_wdata, head_wdata;

  function automatic logic [NW-1:0] base_of(input logic [LW-1:0] l);
    return (MEMC >> l) - NW'(1);
  endfunction

  // rounded size to level: bit length of size minus one
  always_comb begin
    s_m1     = (in_size == '0) ? '0 : in_size - SW'(1);
    size_lvl = '0;
    for (int i = 0; i < SW; i++) begin
      if (s_m1[i]) size_lvl = LW'(i + 1);
    end
  end

  assign rdata    = rd_nil_r ? NIL : mem_q;
  assign head_cur = head_r[lvl_r];
  assign base_cur = base_of(lvl_r);
  assign hit      = (cur_r == target_r);

  // node being pushed
  always_comb begin
    case (cmd.op)
      CMD_PUSH_HI: push_node = base_cur + (NW'(idx_r) << 1) + NW'(1);
      CMD_PUSH_LO: push_node = base_cur + (NW'(idx_r) << 1);
      default:     push_node = base_cur + NW'(idx_r);
    endcase
  end

  // memory and head write selection
  always_comb begin
    mem_re     = (cmd.op == CMD_POP_RD) || (cmd.op == CMD_WALK_RD);
    mem_raddr  = (cmd.op == CMD_WALK_RD) ? cur_r : head_cur;
    mem_we     = 1'b0;
    mem_waddr  = push_node;
    mem_wdata  = head_cur;
    head_we    = 1'b0;
    head_wdata = push_node;
    case (cmd.op)
      CMD_PUSH_HI, CMD_PUSH_LO, CMD_PUSH_FREE: begin
        mem_we  = 1'b1;
        head_we = 1'b1;
      end
      CMD_POP_SPLIT, CMD_POP_TAKE: begin
        head_we    = (node_r != NIL);
        head_wdata = rdata;
      end
      CMD_WALK_CHK: begin
        if (hit) begin
          if (prev_r == NIL) begin
            head_we    = 1'b1;
            head_wdata = rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = prev_r;
            mem_wdata = rdata;
          end
        end
      end
      default: ;
    endcase
  end

  // link memory
  always_ff @(posedge clk) begin
    if (mem_we) node_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= node_mem[mem_raddr];
  end

  // level heads and the never-written flag of the root link
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HD; i++) begin
        head_r[i] <= (i == LEVELS - 1) ? '0 : NIL;
      end
      n0_wr_r  <= 1'b0;
      rd_nil_r <= 1'b0;
    end else begin
      if (head_we) head_r[lvl_r] <= head_wdata;
      if (mem_we && (mem_waddr == '0)) n0_wr_r <= 1'b1;
      if (mem_re) rd_nil_r <= (mem_raddr == '0) && !n0_wr_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        lvl_r  <= size_lvl;
        want_r <= size_lvl;
        idx_r  <= AW'(in_addr >> size_lvl);
        res_r  <= '0;
      end
      CMD_LVL_UP: lvl_r <= lvl_r + LW'(1);
      CMD_POP_RD: node_r <= head_cur;
      CMD_POP_SPLIT: begin
        idx_r <= AW'(node_r - base_cur);
        lvl_r <= lvl_r - LW'(1);
      end
      CMD_POP_TAKE: res_r <= AW'((node_r - base_cur) << lvl_r);
      CMD_WALK_INIT: begin
        prev_r   <= NIL;
        cur_r    <= head_cur;
        target_r <= base_cur + NW'(idx_r ^ AW'(1));
        steps_r  <= (MEMC >> lvl_r) + NW'(1);
      end
      CMD_WALK_CHK: begin
        if (hit) begin
          idx_r <= idx_r >> 1;
          lvl_r <= lvl_r + LW'(1);
        end else begin
          prev_r  <= cur_r;
          cur_r   <= rdata;
          steps_r <= steps_r - NW'(1);
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_addr_r <= cmd.out_fail ? '0 : res_r;
      out_fail_r <= cmd.out_fail;
    end
  end

  // status to the controller
  always_comb begin
    sts.oversize      = (lvl_r >= LW'(LEVELS));
    sts.lvl_empty     = (head_cur == NIL);
    sts.lvl_gt_want   = (lvl_r > want_r);
    sts.lvl_below_top = (lvl_r < LW'(LEVELS - 1));
    sts.walk_live     = (cur_r != NIL) && (steps_r != '0);
    sts.walk_hit      = hit;
    sts.node_bad      = (node_r == NIL);
  end

  assign out_addr = out_addr_r;
  assign out_fail = out_fail_r;

endmodule

FILE: src/bma_ctrl.sv
// Controller of the buddy allocator: sequences search, split, walk and merge.
// Depends on bma_pkg; commands bma_datapath and owns the result valid flag.
module bma_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bma_pkg::dp_sts_t sts,
  output bma_pkg::dp_cmd_t cmd
);
  import bma_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SPLIT_RD,
    ST_SPLIT_WR,
    ST_PUSH_HI,
    ST_PUSH_LO,
    ST_TAKE_RD,
    ST_TAKE_WR,
    ST_FREE_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_PUSH_FREE,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   op_r, fail_r, out_valid_r;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // command decode
  always_comb begin
    cmd.op       = CMD_NONE;
    cmd.out_load = 1'b0;
    cmd.out_fail = fail_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) cmd.op = CMD_LOAD;
      ST_SCAN:      if (!sts.oversize && sts.lvl_empty) cmd.op = CMD_LVL_UP;
      ST_SPLIT_RD:  cmd.op = CMD_POP_RD;
      ST_SPLIT_WR:  cmd.op = CMD_POP_SPLIT;
      ST_PUSH_HI:   cmd.op = CMD_PUSH_HI;
      ST_PUSH_LO:   cmd.op = CMD_PUSH_LO;
      ST_TAKE_RD:   cmd.op = CMD_POP_RD;
      ST_TAKE_WR:   if (!sts.node_bad) cmd.op = CMD_POP_TAKE;
      ST_FREE_CHK:  if (sts.lvl_below_top) cmd.op = CMD_WALK_INIT;
      ST_WALK_RD:   if (sts.walk_live) cmd.op = CMD_WALK_RD;
      ST_WALK_CHK:  cmd.op = CMD_WALK_CHK;
      ST_PUSH_FREE: cmd.op = CMD_PUSH_FREE;
      ST_DONE:      cmd.out_load = out_free;
      default:      ;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ALLOC;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken and no new one posted in this cycle
      if (out_valid_r && out_ready && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            fail_r  <= 1'b0;
            state_r <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (sts.oversize) begin
            fail_r  <= (op_r == OP_ALLOC);
            state_r <= ST_DONE;
          end else begin
            state_r <= (op_r == OP_FREE) ? ST_FREE_CHK : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.oversize) begin
            fail_r  <= 1'b1;
            state_r <= ST_DONE;
          end else if (!sts.lvl_empty) begin
            state_r <= sts.lvl_gt_want ? ST_SPLIT_RD : ST_TAKE_RD;
          end
        end
        ST_SPLIT_RD: state_r <= ST_SPLIT_WR;
        ST_SPLIT_WR: state_r <= ST_PUSH_HI;
        ST_PUSH_HI:  state_r <= ST_PUSH_LO;
        ST_PUSH_LO:  state_r <= sts.lvl_gt_want ? ST_SPLIT_RD : ST_TAKE_RD;
        ST_TAKE_RD:  state_r <= ST_TAKE_WR;
        ST_TAKE_WR: begin
          fail_r  <= sts.node_bad;
          state_r <= ST_DONE;
        end
        ST_FREE_CHK: state_r <= sts.lvl_below_top ? ST_WALK_RD : ST_PUSH_FREE;
        ST_WALK_RD:  state_r <= sts.walk_live ? ST_WALK_CHK : ST_PUSH_FREE;
        ST_WALK_CHK: state_r <= sts.walk_hit ? ST_FREE_CHK : ST_WALK_RD;
        ST_PUSH_FREE: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_buddy_memory_allocator_unit.sv
// Self-checking bench for the buddy allocator unit: random and directed
// allocate/free requests against a behavioral allocator. Uses the unit, bma_pkg.
module tb_buddy_memory_allocator_unit;
  import bma_pkg::*;

  localparam int UNITS = 1024;
  localparam int LVLS = 11;
  localparam int NODES = 2 * UNITS - 1;
  localparam int NIL = NODES;
  localparam int LIMIT = 50000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tuser;

  typedef struct packed {
    logic        op;
    logic [10:0] size;
    logic [9:0]  addr;
  } alloc_req_t;

  typedef struct packed {
    logic [9:0] addr;
    logic       fail;
  } alloc_res_t;

  alloc_req_t pending_reqs[$];
  alloc_res_t expected_res[$];
  int lvl_head[LVLS];
  int node_link[2 * UNITS];
  int live_addr[$];
  int live_lvl[$];
  int errors = 0;
  int cycles = 0;
  int n_alloc = 0, n_free = 0, n_fail = 0, n_results = 0;
  int send_idle = 27, recv_idle = 0;
  bit hold_off = 1'b0;

  buddy_memory_allocator_unit #(.MEM_UNITS(UNITS)) uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int lvl_of(int size);
    int l;
    l = 0;
    if (size == 0) size = 1;
    while (l < LVLS && (1 << l) < size) l++;
    return l;
  endfunction

  function automatic int base_of(int l);
    return (UNITS >> l) - 1;
  endfunction

  function automatic void list_push(int l, int node);
    node_link[node] = lvl_head[l];
    lvl_head[l] = node;
  endfunction

  function automatic int list_pop(int l);
    int node;
    node = lvl_head[l];
    if (node < NODES) lvl_head[l] = (node_link[node] <= NODES) ? node_link[node] : NIL;
    return node;
  endfunction

  function automatic bit list_unlink(int l, int node);
    int prev, cur, steps;
    prev = NIL;
    cur = lvl_head[l];
    steps = (UNITS >> l) + 1;
    while (cur < NODES && steps != 0) begin
      if (cur == node) begin
        if (prev == NIL) lvl_head[l] = node_link[cur];
        else node_link[prev] = node_link[cur];
        return 1'b1;
      end
      prev = cur;
      cur = node_link[cur];
      steps--;
    end
    return 1'b0;
  endfunction

  // behavioral allocator: returns the result one request produces
  function automatic alloc_res_t predict_alloc(alloc_req_t r);
    alloc_res_t res;
    int want, l, node, idx;
    res = '0;
    want = lvl_of(r.size);
    if (r.op == OP_FREE) begin
      if (want < LVLS) begin
        l = want;
        idx = r.addr >> l;
        while (l < LVLS - 1) begin
          if (!list_unlink(l, base_of(l) + (idx ^ 1))) break;
          idx >>= 1;
          l++;
        end
        list_push(l, base_of(l) + idx);
      end
      return res;
    end
    res.fail = 1'b1;
    if (want >= LVLS) return res;
    l = want;
    while (l < LVLS && lvl_head[l] >= NODES) l++;
    if (l >= LVLS) return res;
    while (l > want) begin
      node = list_pop(l);
      idx = node - base_of(l);
      l--;
      list_push(l, base_of(l) + 2 * idx + 1);
      list_push(l, base_of(l) + 2 * idx);
    end
    node = list_pop(want);
    if (node >= NODES) return res;
    res.fail = 1'b0;
    res.addr = 10'(((node - base_of(want)) << want) & (UNITS - 1));
    return res;
  endfunction

  // queue a request with its expected result, tracking live blocks
  task automatic add_req(bit op, int size, int addr);
    alloc_req_t r;
    alloc_res_t p;
    r.op = op;
    r.size = size[10:0];
    r.addr = addr[9:0];
    p = predict_alloc(r);
    if (op == OP_ALLOC) begin
      n_alloc++;
      if (p.fail) n_fail++;
      else begin
        live_addr.push_back(int'(p.addr));
        live_lvl.push_back(lvl_of(size));
      end
    end else n_free++;
    pending_reqs.push_back(r);
    expected_res.push_back(p);
  endtask

  task automatic free_live(int k);
    add_req(OP_FREE, 1 << live_lvl[k], live_addr[k]);
    live_addr.delete(k);
    live_lvl.delete(k);
  endtask

  task automatic wait_drain();
    while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          alloc_req_t r;
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b0, r.addr, r.size};
          in_tuser <= r.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result addr=%0d fail=%0b", $time, out_tdata[9:0], out_tuser);
        errors++;
      end else begin
        alloc_res_t e;
        e = expected_res.pop_front();
        if (out_tdata[9:0] !== e.addr || out_tuser !== e.fail || out_tdata[15:10] !== '0) begin
          $display("%0t: mismatch expected addr=%0d fail=%0b actual addr=%0d fail=%0b",
                   $time, e.addr, e.fail, out_tdata[9:0], out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // model reset state and reset sequence
  initial begin
    int k;
    for (k = 0; k < LVLS; k++) lvl_head[k] = NIL;
    for (k = 0; k < 2 * UNITS; k++) node_link[k] = 0;
    node_link[0] = NIL;
    lvl_head[LVLS - 1] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // stimulus; results are predicted in generation order, which is issue order
  initial begin
    int k, phase, sz;
    @(posedge rst_n);
    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 76 : 0;
      recv_idle = (phase == 0) ? 76 : (phase == 1) ? 27 : 0;
      if (phase == 0) begin
        // directed: extremes, zero size, oversize, unaligned, bogus and top frees
        add_req(OP_ALLOC, 0, 1023);
        add_req(OP_ALLOC, 1, 0);
        add_req(OP_ALLOC, 2047, 0);
        add_req(OP_ALLOC, 1025, 0);
        add_req(OP_ALLOC, 1024, 0);
        add_req(OP_FREE, 2047, 1023);
        add_req(OP_FREE, 0, 1);
        add_req(OP_FREE, 1, 0);
        add_req(OP_ALLOC, 1024, 0);
        add_req(OP_FREE, 1024, 1023);
        add_req(OP_ALLOC, 3, 0);
        add_req(OP_ALLOC, 512, 0);
        add_req(OP_ALLOC, 512, 0);
        add_req(OP_FREE, 512, 700);
        add_req(OP_FREE, 4, 5);
        add_req(OP_FREE, 4, 4);
        add_req(OP_FREE, 1024, 0);
        add_req(OP_FREE, 1024, 0);
        add_req(OP_ALLOC, 1, 0);
        add_req(OP_ALLOC, 1, 0);
        add_req(OP_ALLOC, 1, 0);
        add_req(OP_FREE, 1, 0);
        add_req(OP_FREE, 1, 2);
        add_req(OP_FREE, 1, 1);
        live_addr.delete();
        live_lvl.delete();
      end else begin
        for (k = 0; k < 560; k++) begin
          if (phase == 3 && k == 200) begin
            wait_drain();
            hold_off = 1'b1;
            fork
              begin
                repeat (150) @(posedge clk);
                hold_off = 1'b0;
              end
            join_none
          end
          if ($urandom_range(9) == 0) begin
            add_req($urandom_range(1), $urandom_range(2047), $urandom_range(1023));
          end else if (live_addr.size() != 0 && $urandom_range(1)) begin
            free_live($urandom_range(live_addr.size() - 1));
          end else begin
            sz = $urandom_range(3) == 0 ? $urandom_range(1024) : $urandom_range(16);
            add_req(OP_ALLOC, sz, $urandom_range(1023));
          end
        end
      end
      wait_drain();
    end
    repeat (200) @(posedge clk);
    $display("covered %0d allocates (%0d failed) and %0d frees, %0d results checked",
             n_alloc, n_fail, n_free, n_results);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
